// File: src/pkcs7_pkg.sv
// shared types, constants and codes for the pkcs7 block pad/unpad unit
package pkcs7_pkg;

    localparam int MAX_BLOCK = 32;
    localparam int ADDR_W    = $clog2(MAX_BLOCK);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int DATA_W    = 8;
    localparam int BS_W      = 6;
    localparam int CFG_W     = 6;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_UNPAD_MODE = 1'd1;

    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_LEN = 2'd1;
    localparam logic [1:0] ST_PAD = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [DATA_W-1:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              byte_valid;
        logic              end_of_run;
        logic [1:0]        status;
    } res_t;

    // effective configuration seen by the sequencer
    typedef struct packed {
        logic [CNT_W-1:0] bs;
        logic             unpad;
        logic             clear;
    } cfg_t;

    // buffer port controls
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // one result handed to the output register
    typedef struct packed {
        logic valid;
        res_t item;
    } push_t;

endpackage

// File: src/pkcs7_buf.sv
// block buffer memory: one write port, one read port with registered data
module pkcs7_buf (
    input  logic                           clk,
    input  pkcs7_pkg::mem_req_t            mem_req,
    output logic [pkcs7_pkg::DATA_W-1:0]   rdata
);
    import pkcs7_pkg::*;

    logic [DATA_W-1:0] mem_reg [MAX_BLOCK];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem_reg[mem_req.waddr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rdata_reg <= mem_reg[mem_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/pkcs7_seq.sv
// sequencer: fill count, buffer read engine, pad check and result generation
module pkcs7_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  pkcs7_pkg::req_t                req,
    input  pkcs7_pkg::cfg_t                cfg,
    input  logic                           slot_free,
    input  logic [pkcs7_pkg::DATA_W-1:0]   rdata,
    output pkcs7_pkg::mem_req_t            mem_req,
    output pkcs7_pkg::push_t               push
);
    import pkcs7_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EMIT  = 7'b0000010,
        S_LAST  = 7'b0000100,
        S_LASTW = 7'b0001000,
        S_CHK   = 7'b0010000,
        S_STAT  = 7'b0100000,
        S_WRB   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic [CNT_W-1:0]  pad_reg, pad_next;
    logic              rvld_reg, rvld_next;
    logic              rsel_reg, rsel_next;
    logic              rlast_reg, rlast_next;
    logic              eor_reg, eor_next;
    logic              fin_reg, fin_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              err_reg, err_next;
    logic [1:0]        st_reg, st_next;
    logic [DATA_W-1:0] byte_reg, byte_next;

    logic              accept;
    logic              more;
    logic              consume;
    logic              rd_en;
    logic              engine_on;
    logic [CNT_W-1:0]  fill_p1;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  bs_m1;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign fill_p1   = CNT_W'(fill_reg + 1'b1);
    assign idx_p1    = CNT_W'(idx_reg + 1'b1);
    assign bs_m1     = CNT_W'(cfg.bs - 1'b1);

    // read engine shared by pad check and byte emission
    assign engine_on = (state_reg == S_EMIT) || (state_reg == S_CHK);
    assign more      = (idx_reg != end_reg);
    assign consume   = rvld_reg && ((state_reg == S_CHK) || slot_free);
    assign rd_en     = engine_on && more && (!rvld_reg || consume);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        end_next     = end_reg;
        lim_next     = lim_reg;
        pad_next     = pad_reg;
        rvld_next    = rvld_reg;
        rsel_next    = rsel_reg;
        rlast_next   = rlast_reg;
        eor_next     = eor_reg;
        fin_next     = fin_reg;
        wr_pend_next = wr_pend_reg;
        err_next     = err_reg;
        st_next      = st_reg;
        byte_next    = byte_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = fill_reg[ADDR_W-1:0];
        mem_req.wdata = req.data_byte;
        mem_req.re    = rd_en;
        mem_req.raddr = idx_reg[ADDR_W-1:0];

        push.valid           = 1'b0;
        push.item.out_byte   = rsel_reg ? rdata : DATA_W'(pad_reg);
        push.item.byte_valid = 1'b1;
        push.item.end_of_run = rlast_reg && eor_reg;
        push.item.status     = ST_OK;

        if (rd_en)
        begin
            idx_next   = idx_p1;
            rsel_next  = (idx_reg < lim_reg);
            rlast_next = (idx_p1 == end_reg);
        end
        if (engine_on)
        begin
            rvld_next = rd_en || (rvld_reg && !consume);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next  = '0;
                    end_next  = cfg.bs;
                    lim_next  = cfg.bs;
                    eor_next  = 1'b1;
                    fin_next  = 1'b0;
                    rvld_next = 1'b0;
                    if (req.opcode == OP_DATA)
                    begin
                        if (!cfg.unpad)
                        begin
                            mem_req.we = 1'b1;
                            if (fill_p1 >= cfg.bs)
                            begin
                                fill_next  = '0;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                fill_next = fill_p1;
                            end
                        end
                        else if (fill_reg >= cfg.bs)
                        begin
                            // held block leaves first, new byte lands afterwards
                            byte_next    = req.data_byte;
                            wr_pend_next = 1'b1;
                            fill_next    = '0;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            mem_req.we = 1'b1;
                            fill_next  = fill_p1;
                        end
                    end
                    else if (!cfg.unpad)
                    begin
                        pad_next   = CNT_W'(cfg.bs - fill_reg);
                        lim_next   = fill_reg;
                        fill_next  = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        fill_next = '0;
                        if (fill_reg != cfg.bs)
                        begin
                            st_next    = ST_LEN;
                            state_next = S_STAT;
                        end
                        else
                        begin
                            state_next = S_LAST;
                        end
                    end
                end
            end

            S_EMIT:
            begin
                push.valid = consume;
                if (!more && !rvld_reg)
                begin
                    if (fin_reg)
                    begin
                        st_next    = ST_OK;
                        state_next = S_STAT;
                    end
                    else if (wr_pend_reg)
                    begin
                        state_next = S_WRB;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_LAST:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = bs_m1[ADDR_W-1:0];
                state_next    = S_LASTW;
            end

            S_LASTW:
            begin
                if ((rdata == '0) || (rdata > DATA_W'(cfg.bs)))
                begin
                    st_next    = ST_PAD;
                    state_next = S_STAT;
                end
                else
                begin
                    pad_next   = rdata[CNT_W-1:0];
                    idx_next   = CNT_W'(cfg.bs - rdata[CNT_W-1:0]);
                    end_next   = bs_m1;
                    err_next   = 1'b0;
                    rvld_next  = 1'b0;
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                if (consume && (rdata != DATA_W'(pad_reg)))
                begin
                    err_next = 1'b1;
                end
                if (!more && !rvld_reg)
                begin
                    if (err_reg)
                    begin
                        st_next    = ST_PAD;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        end_next   = CNT_W'(cfg.bs - pad_reg);
                        lim_next   = CNT_W'(cfg.bs - pad_reg);
                        eor_next   = 1'b0;
                        fin_next   = 1'b1;
                        rvld_next  = 1'b0;
                        state_next = S_EMIT;
                    end
                end
            end

            S_STAT:
            begin
                push.item.out_byte   = '0;
                push.item.byte_valid = 1'b0;
                push.item.end_of_run = 1'b1;
                push.item.status     = st_reg;
                if (slot_free)
                begin
                    push.valid = 1'b1;
                    fin_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end

            S_WRB:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = byte_reg;
                fill_next     = CNT_W'(1);
                wr_pend_next  = 1'b0;
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.clear)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            rvld_reg    <= 1'b0;
            wr_pend_reg <= 1'b0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rvld_reg    <= rvld_next;
            wr_pend_reg <= wr_pend_next;
            fin_reg     <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        end_reg   <= end_next;
        lim_reg   <= lim_next;
        pad_reg   <= pad_next;
        rsel_reg  <= rsel_next;
        rlast_reg <= rlast_next;
        eor_reg   <= eor_next;
        err_reg   <= err_next;
        st_reg    <= st_next;
        byte_reg  <= byte_next;
    end

endmodule

// File: src/pkcs7_block_pad_unpad_unit.sv
// top level of the pkcs7 block pad/unpad unit
// a data request that completes no block only writes its byte; one that releases a block
// emits it, in unpad mode writing the new byte back after the held block leaves
// pad finish: buffered bytes then pad bytes; unpad finish: a length error, a bad last byte,
// or pad check and byte output; results leave one per cycle unless stalled
// reset clears control state, fill count and config (block size 16, pad mode), not the buffer
module pkcs7_block_pad_unpad_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  pkcs7_pkg::req_t                   req,
    output logic                              res_valid,
    input  logic                              res_ready,
    output pkcs7_pkg::res_t                   res,
    input  logic                              cfg_wr_en,
    input  logic [pkcs7_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [pkcs7_pkg::CFG_W-1:0]       cfg_data
);
    import pkcs7_pkg::*;

    // configuration registers
    logic [BS_W-1:0]  block_size_reg;
    logic             unpad_mode_reg;
    logic             cfg_hit;
    logic [CNT_W-1:0] bs_eff;
    cfg_t             cfg;

    // output register
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg;
    logic             slot_free;

    push_t            push;
    mem_req_t         mem_req;
    logic [DATA_W-1:0] rdata;

    // any write to a known register clears the fill count, dropping the buffered bytes
    always_comb
    begin
        case (cfg_index)
            REG_BLOCK_SIZE: cfg_hit = cfg_wr_en;
            REG_UNPAD_MODE: cfg_hit = cfg_wr_en;
            default:        cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BS_W'(16);
            unpad_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE: block_size_reg <= cfg_data[BS_W-1:0];
                REG_UNPAD_MODE: unpad_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the buffer depth
    always_comb
    begin
        if (block_size_reg == '0)
        begin
            bs_eff = CNT_W'(1);
        end
        else if (int'(block_size_reg) > MAX_BLOCK)
        begin
            bs_eff = CNT_W'(MAX_BLOCK);
        end
        else
        begin
            bs_eff = CNT_W'(block_size_reg);
        end
    end

    assign cfg.bs    = bs_eff;
    assign cfg.unpad = unpad_mode_reg;
    assign cfg.clear = cfg_hit;

    // output slot frees up when empty or taken this cycle
    assign slot_free = !res_valid_reg || res_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (push.valid)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            res_reg <= push.item;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // sequencer drives the buffer and feeds the output register
    pkcs7_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg       (cfg),
        .slot_free (slot_free),
        .rdata     (rdata),
        .mem_req   (mem_req),
        .push      (push)
    );

    // block buffer
    pkcs7_buf u_buf (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

endmodule

// File: src/pkcs7_chk.sv
// port-level checker for the pkcs7 block pad/unpad unit, with its bind
module pkcs7_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input pkcs7_pkg::req_t                   req,
    input logic                              res_valid,
    input logic                              res_ready,
    input pkcs7_pkg::res_t                   res
);
    import pkcs7_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // a status-only result always closes the run
    a_stat_eor: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.byte_valid |-> res.end_of_run && res.out_byte == '0)
        else $error("status result not last or carries a byte");

    // byte results carry ok status
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.byte_valid |-> res.status == ST_OK)
        else $error("byte result with error status");

    // a finish request always keeps the unit busy for the next cycle
    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.opcode == OP_FINISH |=> !req_ready)
        else $error("request taken right after finish");

endmodule

bind pkcs7_block_pad_unpad_unit pkcs7_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
